[rtl/kmd_pkg.sv]
// shared types and constants for the key matrix debounce and repeat block
`timescale 1ns / 1ps

package kmd_pkg;

    localparam int COLS   = 5;
    localparam int ROWS   = 7;
    localparam int KEYS   = COLS * ROWS;
    localparam int IDX_W  = $clog2(KEYS);
    localparam int COL_W  = 3;
    localparam int ROW_W  = 3;
    localparam int TICK_W = 32;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 3;
    localparam int MOD_W  = 5;
    localparam int SET_W  = 2;
    localparam int KIDX_W = 6;

    localparam int IN_W  = 40;
    localparam int OUT_W = 16;

    // modifier flag bit positions
    localparam int FLAG_SYM = 0;
    localparam int FLAG_ALT = 1;
    localparam int FLAG_LSH = 2;
    localparam int FLAG_RSH = 3;
    localparam int FLAG_MIC = 4;

    typedef enum logic [CIDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_REPEAT   = 3'd1,
        CFG_SYM_IDX  = 3'd2,
        CFG_ALT_IDX  = 3'd3,
        CFG_LSH_IDX  = 3'd4,
        CFG_RSH_IDX  = 3'd5,
        CFG_MIC_IDX  = 3'd6
    } t_cfg_idx;

    typedef enum logic [SET_W-1:0] {
        CS_LOWER  = 2'd0,
        CS_UPPER  = 2'd1,
        CS_SYMBOL = 2'd2
    } t_char_set;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_time;
        logic [TICK_W-1:0] repeat_time;
        logic [KIDX_W-1:0] sym_idx;
        logic [KIDX_W-1:0] alt_idx;
        logic [KIDX_W-1:0] lsh_idx;
        logic [KIDX_W-1:0] rsh_idx;
        logic [KIDX_W-1:0] mic_idx;
    } t_cfg;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              pressed;
        logic [TICK_W-1:0] tick;
        logic [IDX_W-1:0]  idx;
        logic              in_range;
    } t_item;

    typedef struct packed {
        logic [COL_W-1:0] key_col;
        logic [ROW_W-1:0] key_row;
        t_char_set        char_set;
        logic [MOD_W-1:0] held_modifiers;
    } t_result;

    typedef struct packed {
        logic              wr_dl;
        logic [TICK_W-1:0] dl_value;
        logic              set_latch;
        logic              clr_latch;
        logic [MOD_W-1:0]  flags_next;
        logic              emit;
        t_result           result;
    } t_eval;

endpackage

[rtl/kmd_deadline_mem.sv]
// per-key deadline memory with valid bits and write-to-read bypass
`timescale 1ns / 1ps

module kmd_deadline_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [kmd_pkg::IDX_W-1:0]  i_wr_addr,
    input  logic [kmd_pkg::TICK_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [kmd_pkg::IDX_W-1:0]  i_rd_addr,
    output logic [kmd_pkg::TICK_W-1:0] o_rd_data
);
    import kmd_pkg::*;

    logic [TICK_W-1:0] r_mem [KEYS];
    logic [KEYS-1:0]   r_valid;
    logic [TICK_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // a never-written entry reads as zero; same-edge write is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else if (r_valid[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/kmd_key_eval.sv]
// debounce, repeat and modifier decision for one sampled key
`timescale 1ns / 1ps

module kmd_key_eval (
    input  kmd_pkg::t_item             i_item,
    input  logic                      i_latched,
    input  logic [kmd_pkg::TICK_W-1:0] i_deadline,
    input  logic [kmd_pkg::MOD_W-1:0]  i_flags,
    input  kmd_pkg::t_cfg              i_cfg,
    output kmd_pkg::t_eval             o_eval
);
    import kmd_pkg::*;

    logic              due;
    logic              press_new;
    logic              release_key;
    logic              repeat_key;
    logic              down;
    logic              is_mod;
    logic [KIDX_W-1:0] kidx;
    logic [MOD_W-1:0]  flags;
    t_char_set         cset;

    always_comb begin
        kidx        = KIDX_W'(i_item.idx);
        due         = i_item.tick >= i_deadline;
        press_new   = i_item.in_range && i_item.pressed && !i_latched && due;
        release_key = i_item.in_range && !i_item.pressed && i_latched;
        repeat_key  = i_item.in_range && i_item.pressed && i_latched && due;
        down        = press_new || repeat_key;

        flags  = i_flags;
        is_mod = 1'b0;
        if (down) begin
            priority if (kidx == i_cfg.sym_idx) begin
                flags[FLAG_SYM] = 1'b1;
                is_mod          = 1'b1;
            end else if (kidx == i_cfg.alt_idx) begin
                flags[FLAG_ALT] = 1'b1;
                is_mod          = 1'b1;
            end else if (kidx == i_cfg.lsh_idx) begin
                flags[FLAG_LSH] = 1'b1;
                is_mod          = 1'b1;
            end else if (kidx == i_cfg.rsh_idx) begin
                flags[FLAG_RSH] = 1'b1;
                is_mod          = 1'b1;
            end else if (!i_flags[FLAG_SYM] && kidx == i_cfg.mic_idx) begin
                // mic counts as a modifier only while symbol is up
                flags[FLAG_MIC] = 1'b1;
                is_mod          = 1'b1;
            end else begin
                is_mod = 1'b0;
            end
        end else if (release_key) begin
            priority if (kidx == i_cfg.sym_idx) begin
                flags[FLAG_SYM] = 1'b0;
            end else if (kidx == i_cfg.alt_idx) begin
                flags[FLAG_ALT] = 1'b0;
            end else if (kidx == i_cfg.lsh_idx) begin
                flags[FLAG_LSH] = 1'b0;
            end else if (kidx == i_cfg.rsh_idx) begin
                flags[FLAG_RSH] = 1'b0;
            end else if (kidx == i_cfg.mic_idx) begin
                flags[FLAG_MIC] = 1'b0;
            end else begin
                flags = i_flags;
            end
        end

        if (flags[FLAG_SYM]) begin
            cset = CS_SYMBOL;
        end else if (flags[FLAG_LSH] || flags[FLAG_RSH]) begin
            cset = CS_UPPER;
        end else begin
            cset = CS_LOWER;
        end

        o_eval.wr_dl     = down || release_key;
        o_eval.dl_value  = i_item.tick
                         + (repeat_key ? i_cfg.repeat_time : i_cfg.debounce_time);
        o_eval.set_latch = down;
        o_eval.clr_latch = release_key;
        o_eval.flags_next = flags;
        o_eval.emit      = down && !is_mod;
        o_eval.result.key_col        = i_item.col;
        o_eval.result.key_row        = i_item.row;
        o_eval.result.char_set       = cset;
        o_eval.result.held_modifiers = flags;
    end

endmodule

[rtl/key_matrix_debounce_repeat_modifiers.sv]
// top level: key sample stream in, character beats out, config registers
`timescale 1ns / 1ps
//
//  channel   | signals                         | contents (low bits first)
//  ----------+---------------------------------+------------------------------------
//  s_axis in | i_s_axis_tvalid/tready/tdata    | col 3, row 3, pressed 1, tick 32
//  m_axis out| o_m_axis_tvalid/tready/tdata    | col 3, row 3, char_set 2, mods 5
//  config    | i_cfg_we, i_cfg_index, i_cfg_data | register write, no read-back
//
//  one sample per cycle sustained while the output does not stall; an accepted sample
//  enters the eval register as the deadline memory read starts, and a beat it emits
//  enters the output register, raising o_m_axis_tvalid, when the eval stage advances.
//  the deadline memory has one write and one registered read port with bypass.
//  reset clears latches, valid bits, flags, both handshake stages; config takes defaults.
//  a stalled output holds the eval stage, which then holds the input side.
//
module key_matrix_debounce_repeat_modifiers (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // col [2:0], row [5:3], pressed [6], tick [38:7], zero [39]
    input  logic [kmd_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // key_col [2:0], key_row [5:3], char_set [7:6], held_modifiers [12:8], zero [15:13]
    output logic [kmd_pkg::OUT_W-1:0]   o_m_axis_tdata,
    input  logic                       i_cfg_we,
    input  logic [kmd_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [kmd_pkg::CFG_W-1:0]   i_cfg_data
);
    import kmd_pkg::*;

    t_cfg              r_cfg;
    t_item             r_s1;
    logic              r_s1_valid;
    logic [KEYS-1:0]   r_latch;
    logic [MOD_W-1:0]  r_flags;
    t_result           r_out;
    logic              r_out_valid;

    t_item             n_item;
    t_eval             eval;
    logic [TICK_W-1:0] deadline;
    logic              s1_adv;
    logic              in_accept;
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;

    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        in_col          = i_s_axis_tdata[COL_W-1:0];
        in_row          = i_s_axis_tdata[COL_W+ROW_W-1:COL_W];
        n_item.col      = in_col;
        n_item.row      = in_row;
        n_item.pressed  = i_s_axis_tdata[COL_W+ROW_W];
        n_item.tick     = i_s_axis_tdata[COL_W+ROW_W+TICK_W:COL_W+ROW_W+1];
        n_item.in_range = (int'(in_col) < COLS) && (int'(in_row) < ROWS);
        // out-of-range samples park on key 0 and are dropped in eval
        n_item.idx      = n_item.in_range ? IDX_W'(int'(in_col) * ROWS + int'(in_row))
                                          : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= '0;
            r_cfg.repeat_time   <= '0;
            r_cfg.sym_idx       <= KIDX_W'(0);
            r_cfg.alt_idx       <= KIDX_W'(1);
            r_cfg.lsh_idx       <= KIDX_W'(2);
            r_cfg.rsh_idx       <= KIDX_W'(3);
            r_cfg.mic_idx       <= KIDX_W'(4);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE: r_cfg.debounce_time <= i_cfg_data;
                CFG_REPEAT:   r_cfg.repeat_time   <= i_cfg_data;
                CFG_SYM_IDX:  r_cfg.sym_idx       <= i_cfg_data[KIDX_W-1:0];
                CFG_ALT_IDX:  r_cfg.alt_idx       <= i_cfg_data[KIDX_W-1:0];
                CFG_LSH_IDX:  r_cfg.lsh_idx       <= i_cfg_data[KIDX_W-1:0];
                CFG_RSH_IDX:  r_cfg.rsh_idx       <= i_cfg_data[KIDX_W-1:0];
                CFG_MIC_IDX:  r_cfg.mic_idx       <= i_cfg_data[KIDX_W-1:0];
                default: ;
            endcase
        end
    end

    kmd_deadline_mem u_dl_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (s1_adv && eval.wr_dl),
        .i_wr_addr (r_s1.idx),
        .i_wr_data (eval.dl_value),
        .i_rd_en   (in_accept),
        .i_rd_addr (n_item.idx),
        .o_rd_data (deadline)
    );

    kmd_key_eval u_eval (
        .i_item     (r_s1),
        .i_latched  (r_latch[r_s1.idx]),
        .i_deadline (deadline),
        .i_flags    (r_flags),
        .i_cfg      (r_cfg),
        .o_eval     (eval)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
            r_flags <= '0;
        end else if (s1_adv) begin
            r_flags <= eval.flags_next;
            if (eval.set_latch) begin
                r_latch[r_s1.idx] <= 1'b1;
            end else if (eval.clr_latch) begin
                r_latch[r_s1.idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && eval.emit) begin
            r_out <= eval.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= eval.emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.held_modifiers, r_out.char_set,
                              r_out.key_row, r_out.key_col};

`ifndef SYNTHESIS
    a_no_emit_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && eval.emit) |-> r_s1.in_range)
        else $error("character beat from an out-of-range sample");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled while a stage is free");

    a_latch_after_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && eval.set_latch) |=> r_latch[$past(r_s1.idx)])
        else $error("pressed key not latched");

    a_symbol_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && eval.emit && eval.flags_next[FLAG_SYM])
            |-> (eval.result.char_set == CS_SYMBOL))
        else $error("symbol held but character set not symbol");

    a_beat_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && eval.emit) |=> o_m_axis_tvalid)
        else $error("emitted character did not reach the output");
`endif

endmodule
